// ----- rtl/ifa_pkg.sv -----
// Shared types and constants for the integer to ASCII formatter.
// Holds the channel word types, the digit cell control struct and the character table.
// No dependencies.
`timescale 1ns / 1ps

package ifa_pkg;

  // Number of digit cells: 2^64 needs twenty decimal digits, sixteen hex.
  localparam int NCELL = 20;

  // Digit cell operations.
  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_CLEAR  = 2'd1;
  localparam logic [1:0] CELL_CONV   = 2'd2;
  localparam logic [1:0] CELL_DSHIFT = 2'd3;

  // Fixed characters.
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  // One input word.
  typedef struct packed {
    logic [63:0] value;
    logic        is_signed;
    logic        use_hex;
    logic [4:0]  width;
    logic        zero_pad;
  } in_word_t;

  // One result word.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_word_t;

  // Control shared by every cell of the row.
  typedef struct packed {
    logic [1:0] mode;
    logic       dec;
  } cell_ctrl_t;

  // Lower-case hex digit to ASCII.
  function automatic logic [7:0] hex_char(input logic [3:0] d);
    logic [7:0] c;
    case (d)
      4'h0: c = 8'h30;
      4'h1: c = 8'h31;
      4'h2: c = 8'h32;
      4'h3: c = 8'h33;
      4'h4: c = 8'h34;
      4'h5: c = 8'h35;
      4'h6: c = 8'h36;
      4'h7: c = 8'h37;
      4'h8: c = 8'h38;
      4'h9: c = 8'h39;
      4'ha: c = 8'h61;
      4'hb: c = 8'h62;
      4'hc: c = 8'h63;
      4'hd: c = 8'h64;
      4'he: c = 8'h65;
      default: c = 8'h66;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/ifa_cell.sv -----
// One digit cell of the conversion row: holds a four-bit digit.
// Performs the shift-and-add-three step for decimal, a plain bit shift for hex,
// and whole-digit shifts towards the most significant end. Depends on ifa_pkg.
`timescale 1ns / 1ps

module ifa_cell
  import ifa_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       bit_in,
  input  logic [3:0] dig_in,
  output logic       bit_out,
  output logic [3:0] dig_out
);

  logic [3:0] dig_r;
  logic [3:0] dig_nxt;
  logic [3:0] adj;

  // Decimal correction before the shift keeps each digit within 0 to 9.
  assign adj     = (ctrl.dec && (dig_r >= 4'd5)) ? (dig_r + 4'd3) : dig_r;
  assign bit_out = adj[3];
  assign dig_out = dig_r;

  always_comb begin
    case (ctrl.mode)
      CELL_CLEAR:  dig_nxt = 4'd0;
      CELL_CONV:   dig_nxt = {adj[2:0], bit_in};
      CELL_DSHIFT: dig_nxt = dig_in;
      default:     dig_nxt = dig_r;
    endcase
  end

  always_ff @(posedge clk) begin
    dig_r <= dig_nxt;
  end

endmodule

// ----- rtl/integer_to_ascii_formatter.sv -----
// Top level of the integer to ASCII formatter.
// Sequencer, magnitude shift register, output register and the row of ifa_cell
// digit cells. Depends on ifa_pkg and ifa_cell.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid, in_stall, in_data) takes one word: a 64-bit value,
// signed flag, base select, minimum field width and pad choice. The result
// channel (out_valid, out_stall, out_data) returns one ASCII character per word,
// most significant first, with last set on the final character of the item.
// A new input word is taken only while the block is idle; in_stall is high from
// acceptance until the last character has been loaded into the output register.
// The value is shifted bit-serially, top bit first, into a row of twenty digit
// cells, then leading zero digits are shifted out at one per cycle (up to 19,
// keeping at least one) and the padding is settled; then one character is loaded
// per cycle whenever the output register is free.
// While out_stall is high the output register holds its word and the sequencer
// waits. Reset empties the output register and returns the sequencer to idle.

module integer_to_ascii_formatter
  import ifa_pkg::*;
#(
  parameter int MAX_WIDTH = 24
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  // Largest width that the five-bit field can request after saturation.
  localparam int WCAP = (MAX_WIDTH < 31) ? MAX_WIDTH : 31;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_NORM = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_PAD  = 3'd4;
  localparam logic [2:0] ST_DIG  = 3'd5;

  logic [2:0]  state_r, state_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [4:0]  nd_r, nd_nxt;
  logic [4:0]  pad_r, pad_nxt;
  logic [4:0]  body_r, body_nxt;
  logic        neg_r, neg_nxt;
  logic        dec_r, dec_nxt;
  logic        zp_r, zp_nxt;
  logic [63:0] val_r, val_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_r, out_nxt;

  cell_ctrl_t  ctrl;
  logic [3:0]  dig [NCELL];
  logic        carry [NCELL];
  logic [3:0]  top_dig;
  logic        out_free;
  logic        in_neg;
  logic [4:0]  w_sat;
  logic [4:0]  pad_calc;

  // Row of digit cells; cell 0 is the least significant digit.
  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    if (k == 0) begin : g_first
      ifa_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .bit_in  (val_r[63]),
        .dig_in  (4'd0),
        .bit_out (carry[k]),
        .dig_out (dig[k])
      );
    end else begin : g_next
      ifa_cell u_cell (
        .clk     (clk),
        .ctrl    (ctrl),
        .bit_in  (carry[k-1]),
        .dig_in  (dig[k-1]),
        .bit_out (carry[k]),
        .dig_out (dig[k])
      );
    end
  end

  assign top_dig   = dig[NCELL-1];
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Sign detection and width saturation for the incoming word.
  assign in_neg = !in_data.use_hex && in_data.is_signed && in_data.value[63];
  assign w_sat  = (in_data.width > 5'(WCAP)) ? 5'(WCAP) : in_data.width;

  // Padding needed once the digit count is known.
  assign pad_calc = (body_r > nd_r) ? (body_r - nd_r) : 5'd0;

  // Sequencer and output register control.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    nd_nxt        = nd_r;
    pad_nxt       = pad_r;
    body_nxt      = body_r;
    neg_nxt       = neg_r;
    dec_nxt       = dec_r;
    zp_nxt        = zp_r;
    val_nxt       = val_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctrl.mode     = CELL_HOLD;
    ctrl.dec      = dec_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          ctrl.mode = CELL_CLEAR;
          neg_nxt   = in_neg;
          dec_nxt   = !in_data.use_hex;
          zp_nxt    = in_data.zero_pad;
          val_nxt   = in_neg ? (~in_data.value + 64'd1) : in_data.value;
          if (in_neg) begin
            body_nxt = (w_sat != 5'd0) ? (w_sat - 5'd1) : 5'd0;
          end else begin
            body_nxt = w_sat;
          end
          cnt_nxt   = 6'd0;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        // One value bit enters the cell row per cycle, top bit first.
        ctrl.mode = CELL_CONV;
        val_nxt   = {val_r[62:0], 1'b0};
        cnt_nxt   = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          nd_nxt    = 5'(NCELL);
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        // Drop leading zero digits, always keeping at least one.
        if ((nd_r > 5'd1) && (top_dig == 4'd0)) begin
          ctrl.mode = CELL_DSHIFT;
          nd_nxt    = nd_r - 5'd1;
        end else begin
          pad_nxt = pad_calc;
          if (neg_r) begin
            state_nxt = ST_SIGN;
          end else if (pad_calc != 5'd0) begin
            state_nxt = ST_PAD;
          end else begin
            state_nxt = ST_DIG;
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt.ch    = CH_MINUS;
          out_nxt.last  = 1'b0;
          state_nxt     = (pad_r != 5'd0) ? ST_PAD : ST_DIG;
        end
      end
      ST_PAD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt.ch    = zp_r ? CH_ZERO : CH_SPACE;
          out_nxt.last  = 1'b0;
          pad_nxt       = pad_r - 5'd1;
          if (pad_r == 5'd1) begin
            state_nxt = ST_DIG;
          end
        end
      end
      ST_DIG: begin
        // Emit the top digit and move the rest up one cell.
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt.ch    = hex_char(top_dig);
          out_nxt.last  = (nd_r == 5'd1);
          ctrl.mode     = CELL_DSHIFT;
          nd_nxt        = nd_r - 5'd1;
          if (nd_r == 5'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= 6'd0;
      nd_r        <= 5'd0;
      pad_r       <= 5'd0;
      val_r       <= 64'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      nd_r        <= nd_nxt;
      pad_r       <= pad_nxt;
      val_r       <= val_nxt;
    end
  end

  // Per-item settings and the output word.
  always_ff @(posedge clk) begin
    body_r <= body_nxt;
    neg_r  <= neg_nxt;
    dec_r  <= dec_nxt;
    zp_r   <= zp_nxt;
    out_r  <= out_nxt;
  end

`ifndef SYNTHESIS
  // Conversion always hands over to normalisation after the last bit.
  a_conv_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV && cnt_r == 6'd63) |=> (state_r == ST_NORM))
    else $error("conversion did not end after 64 bits");

  // A leading zero digit is always removed while more than one digit remains.
  a_norm_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NORM && nd_r > 5'd1 && top_dig == 4'd0)
      |=> (nd_r == $past(nd_r) - 5'd1))
    else $error("leading zero digit not removed");

  // The digit phase never runs with an empty digit count.
  a_dig_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIG) |-> (nd_r != 5'd0))
    else $error("digit phase with no digits left");

  // Loading the final digit marks it last and frees the input side.
  a_last_char: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIG && out_free && nd_r == 5'd1)
      |=> (state_r == ST_IDLE && out_valid_r && out_r.last))
    else $error("final character not marked last");
`endif

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for integer_to_ascii_formatter: directed and random words,
// with characters checked against a formatter model written here in SystemVerilog.
// Depends on ifa_pkg and the formatter RTL.
`timescale 1ns / 1ps

module tb
  import ifa_pkg::*;
();

  localparam int MAX_FIELD   = 24;
  localparam int RANDOM_WORDS = 405;
  localparam int CALM_WORDS  = 40;
  localparam int HOLD_AT     = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int IDLE_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 120;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  in_word_t  pending_words[$];
  out_word_t expected_chars[$];

  int  word_total = 0;
  int  words_taken = 0;
  int  chars_seen = 0;
  int  neg_words = 0;
  int  hex_words = 0;
  int  wide_words = 0;
  int  errors = 0;
  int  idle_cycles = 0;
  int  send_gap = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;
  bit  in_taken = 1'b0;
  bit  calm;

  integer_to_ascii_formatter #(.MAX_WIDTH(MAX_FIELD)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // The tail of the run goes without any idling on either side.
  assign calm = (words_taken >= word_total - CALM_WORDS);

  // Work out the characters that one word should produce and queue them.
  function automatic void render_text(input in_word_t w);
    logic [63:0] mag;
    logic [63:0] base;
    logic [63:0] rem;
    logic [3:0]  digits [0:MAX_FIELD-1];
    logic [7:0]  text[$];
    logic [7:0]  pad;
    logic        neg;
    int          field;
    int          ndig;
    int          i;
    out_word_t   c;
    field = (w.width > MAX_FIELD) ? MAX_FIELD : int'(w.width);
    base = w.use_hex ? 64'd16 : 64'd10;
    pad = w.zero_pad ? CH_ZERO : CH_SPACE;
    neg = !w.use_hex && w.is_signed && w.value[63];
    mag = neg ? (~w.value + 64'd1) : w.value;
    // Digits come out least significant first.
    ndig = 0;
    do begin
      rem = mag % base;
      mag = mag / base;
      digits[ndig] = rem[3:0];
      ndig++;
    end while (mag != 0 && ndig < MAX_FIELD);
    // The sign counts toward the field, and padding sits between sign and digits.
    if (neg) begin
      text.push_back(CH_MINUS);
      if (field > 0) field--;
    end
    for (i = ndig; i < field; i++) text.push_back(pad);
    for (i = ndig; i > 0; i--) begin
      if (digits[i-1] < 4'd10) text.push_back(8'h30 + 8'(digits[i-1]));
      else text.push_back(8'h61 + 8'(digits[i-1]) - 8'd10);
    end
    for (i = 0; i < text.size(); i++) begin
      c.ch = text[i];
      c.last = (i == text.size() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  function automatic void queue_word(input logic [63:0] v, input bit sgn, input bit hex,
                                     input logic [4:0] w, input bit zp);
    in_word_t item;
    item.value = v;
    item.is_signed = sgn;
    item.use_hex = hex;
    item.width = w;
    item.zero_pad = zp;
    pending_words.push_back(item);
  endfunction

  // Random values lean towards the places where digit counts change.
  function automatic logic [63:0] pick_value();
    logic [63:0] p;
    int k;
    p = 64'd1;
    case ($urandom_range(0, 6))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(0, 999));
      2: return -64'($urandom_range(1, 100000));
      3: return 64'd1 << $urandom_range(0, 63);
      4: begin
        k = $urandom_range(0, 19);
        repeat (k) p = p * 64'd10;
        return p + 64'($urandom_range(0, 2)) - 64'd1;
      end
      5: return (64'd1 << (4 * $urandom_range(1, 15))) - 64'($urandom_range(0, 1));
      default: return 64'($urandom);
    endcase
  endfunction

  // Sender: offers words from the pending queue, with occasional gaps between them.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_words.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= pending_words.pop_front();
        if (!calm && $urandom_range(0, 3) == 0) send_gap <= $urandom_range(1, 9);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off so the block backs up.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && words_taken == HOLD_AT) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: checks each character taken and predicts the text of each word taken.
  always @(posedge clk) begin
    out_word_t want;
    in_taken <= in_valid && !in_stall;
    if (rst_n && ((out_valid && !out_stall) || (in_valid && !in_stall))) idle_cycles = 0;
    else idle_cycles++;
    if (rst_n && out_valid && !out_stall) begin
      chars_seen++;
      if (expected_chars.size() == 0) begin
        $error("unexpected character %h (last %b)", out_data.ch, out_data.last);
        errors++;
      end else begin
        want = expected_chars.pop_front();
        if (out_data.ch !== want.ch) begin
          $error("ch: expected %h, got %h", want.ch, out_data.ch);
          errors++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %b, got %b", want.last, out_data.last);
          errors++;
        end
      end
    end
    if (rst_n && in_valid && !in_stall) begin
      render_text(in_data);
      words_taken++;
      if (in_data.use_hex) hex_words++;
      else if (in_data.is_signed && in_data.value[63]) neg_words++;
      if (in_data.width > MAX_FIELD) wide_words++;
    end
  end

  // Watchdog: gives up when neither channel has moved for too long.
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("FAIL integer_to_ascii_formatter");
    $finish;
  end

  initial begin
    // Directed words: extremes, both bases, padding choices and the corner cases.
    queue_word(64'd0, 1'b0, 1'b0, 5'd0, 1'b0);
    queue_word(64'd0, 1'b1, 1'b1, 5'd0, 1'b1);
    queue_word('1, 1'b0, 1'b0, 5'd0, 1'b0);
    queue_word('1, 1'b1, 1'b0, 5'd0, 1'b0);
    queue_word(64'h8000_0000_0000_0000, 1'b1, 1'b0, 5'd0, 1'b0);
    queue_word(64'h8000_0000_0000_0000, 1'b1, 1'b0, 5'd24, 1'b1);
    queue_word('1, 1'b1, 1'b1, 5'd0, 1'b0);
    queue_word(64'h8000_0000_0000_0000, 1'b1, 1'b1, 5'd31, 1'b1);
    queue_word(64'd123, 1'b0, 1'b0, 5'd10, 1'b0);
    queue_word(64'd123, 1'b0, 1'b0, 5'd10, 1'b1);
    queue_word(-64'd42, 1'b1, 1'b0, 5'd6, 1'b0);
    queue_word(-64'd42, 1'b1, 1'b0, 5'd6, 1'b1);
    queue_word(64'hdead_beef, 1'b0, 1'b1, 5'd12, 1'b1);
    queue_word(64'd12345, 1'b0, 1'b0, 5'd3, 1'b1);
    queue_word(-64'd5, 1'b1, 1'b0, 5'd1, 1'b1);
    queue_word(-64'd5, 1'b1, 1'b0, 5'd0, 1'b0);
    queue_word(64'd7, 1'b0, 1'b0, 5'd24, 1'b0);
    queue_word(64'd7, 1'b0, 1'b0, 5'd25, 1'b1);
    queue_word(64'h0123_4567_89ab_cdef, 1'b0, 1'b1, 5'd16, 1'b0);
    queue_word(64'd9, 1'b0, 1'b0, 5'd31, 1'b0);
    queue_word(64'd10, 1'b0, 1'b0, 5'd0, 1'b0);
    queue_word(64'hfedc_ba98_7654_3210, 1'b0, 1'b0, 5'd5, 1'b0);
    queue_word(64'd1, 1'b1, 1'b0, 5'd2, 1'b1);
    queue_word(64'h7fff_ffff_ffff_ffff, 1'b1, 1'b0, 5'd21, 1'b0);
    queue_word(64'd15, 1'b0, 1'b1, 5'd2, 1'b0);

    // Random words, mostly with widths inside the buffer.
    repeat (RANDOM_WORDS) begin
      queue_word(pick_value(), 1'($urandom), 1'($urandom),
                 ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
                                             : 5'($urandom_range(0, MAX_FIELD)),
                 1'($urandom));
    end
    word_total = pending_words.size();

    repeat (4) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (words_taken < word_total) @(negedge clk);
    while (expected_chars.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run took %0d words (%0d negative decimal, %0d hex, %0d over-wide)",
             words_taken, neg_words, hex_words, wide_words);
    $display("and checked %0d characters.", chars_seen);
    if (errors == 0) begin
      $display("PASS integer_to_ascii_formatter");
    end else begin
      $display("FAIL integer_to_ascii_formatter");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ifa_pkg.sv
rtl/ifa_cell.sv
rtl/integer_to_ascii_formatter.sv
tb/tb.sv
